FILE: rtl/mfld_pkg.sv
// Shared types and constants for the monochrome frame buffer line drawer.
// No dependencies; imported by mfld_front, mfld_back and the top level.
`default_nettype none

package mfld_pkg;

  localparam int unsigned ROWS_PER_BYTE = 8;
  localparam int unsigned COORD_W       = 8;
  localparam int unsigned GEOM_W        = 9;
  localparam int unsigned ERR_W         = 11;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;

  // Command codes on the command port.
  localparam logic [1:0] CMD_LINE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_FILL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    OP_LINE,
    OP_READ,
    OP_FILL,
    OP_NONE
  } op_e;

  // Decoded command, with the line deltas already worked out.
  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               on;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy_mag;
    logic               step_x_neg;
    logic               step_y_neg;
  } cmd_t;

  // Active screen geometry after clipping to the store size.
  typedef struct packed {
    logic [GEOM_W-1:0] width;
    logic [GEOM_W-1:0] height;
  } geom_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_PIX_RD,
    ST_FILL,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/mfld_front.sv
// Front end: accepts commands, decodes them and keeps them in a two-entry queue.
// Depends on mfld_pkg.
`default_nettype none

module mfld_front
  import mfld_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [1:0]         command_i,
  input  wire logic [COORD_W-1:0] start_x_i,
  input  wire logic [COORD_W-1:0] start_y_i,
  input  wire logic [COORD_W-1:0] end_x_i,
  input  wire logic [COORD_W-1:0] end_y_i,
  input  wire logic               pixel_on_i,
  input  wire logic               hold_i,
  output logic                    full_o,
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  wire logic               cmd_pop_i
);

  cmd_t       dec;
  cmd_t       q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  always_comb begin
    unique case (command_i)
      CMD_LINE: dec.op = OP_LINE;
      CMD_READ: dec.op = OP_READ;
      CMD_FILL: dec.op = OP_FILL;
      default:  dec.op = OP_NONE;
    endcase
    dec.x0         = start_x_i;
    dec.y0         = start_y_i;
    dec.x1         = end_x_i;
    dec.y1         = end_y_i;
    dec.on         = pixel_on_i;
    dec.dx         = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    dec.dy_mag     = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    dec.step_x_neg = !(start_x_i < end_x_i);
    dec.step_y_neg = !(start_y_i < end_y_i);
  end

  // Nothing is taken while the back end is clearing the store after reset.
  assign full_o      = (cnt_q == 2'd2) || hold_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfld_back.sv
// Back end: frame store memory and the sequencer that walks lines, reads and fills.
// Depends on mfld_pkg.
`default_nettype none

module mfld_back
  import mfld_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire geom_t geom_i,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output logic       res_value_o,
  output logic       clearing_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);
  localparam int unsigned PageW = COORD_W - 3;
  localparam int unsigned ProdW = GEOM_W + PageW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(STORE_DEPTH - 1);

  logic [7:0] mem [STORE_DEPTH];

  state_e state_q, state_d;
  logic [AddrW-1:0] sweep_q, sweep_d;
  logic on_q, on_d;

  logic [COORD_W-1:0] px_q, py_q, qx_q, qy_q;
  logic [COORD_W-1:0] dx_q, dym_q;
  logic               sxn_q, syn_q, is_read_q;
  logic signed [ERR_W-1:0] err_q;
  logic [AddrW-1:0]   addr_q;
  logic               vis_q;
  logic [2:0]         bit_q;
  logic [7:0]         rdata_q;

  logic [ProdW-1:0]   page_off, addr_full;
  logic [AddrW-1:0]   raddr;
  logic               visible, line_done, step_x, step_y, rd_en;
  logic signed [ERR_W-1:0] dx_s, dy_s, err_next;
  logic signed [ERR_W:0]   e2;
  logic               mem_we;
  logic [AddrW-1:0]   waddr;
  logic [7:0]         wdata, mask;

  // Byte address x + width * (y / 8); always inside the store when on screen.
  assign page_off  = geom_i.width * ProdW'(py_q[COORD_W-1:3]);
  assign addr_full = ProdW'(px_q) + page_off;
  assign raddr     = addr_full[AddrW-1:0];
  assign visible   = ({1'b0, px_q} < geom_i.width) && ({1'b0, py_q} < geom_i.height);
  assign line_done = (px_q == qx_q) && (py_q == qy_q);

  always_comb begin
    dx_s     = signed'(ERR_W'(dx_q));
    dy_s     = -signed'(ERR_W'(dym_q));
    e2       = signed'({err_q, 1'b0});
    step_x   = e2 >= (ERR_W+1)'(dy_s);
    step_y   = e2 <= (ERR_W+1)'(dx_s);
    err_next = err_q + (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (sweep_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LINE: state_d = ST_LINE_RD;
            OP_READ: state_d = ST_PIX_RD;
            OP_FILL: state_d = ST_FILL;
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_LINE_RD: state_d = ST_LINE_WR;
      ST_LINE_WR: state_d = line_done ? ST_RESULT : ST_LINE_RD;
      ST_PIX_RD:  state_d = ST_RESULT;
      ST_FILL:    if (sweep_q == LastAddr) state_d = ST_RESULT;
      ST_RESULT:  if (!res_full_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mask        = 8'(1) << bit_q;
    cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
    rd_en       = (state_q == ST_LINE_RD) || (state_q == ST_PIX_RD);
    clearing_o  = (state_q == ST_CLEAR);
    res_push_o  = (state_q == ST_RESULT) && !res_full_i;
    res_value_o = is_read_q && vis_q && rdata_q[bit_q];
    mem_we      = 1'b0;
    waddr       = sweep_q;
    wdata       = {8{on_q}};
    unique case (state_q)
      ST_CLEAR, ST_FILL: mem_we = 1'b1;
      ST_LINE_WR: begin
        mem_we = vis_q;
        waddr  = addr_q;
        wdata  = on_q ? (rdata_q | mask) : (rdata_q & ~mask);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    sweep_d = sweep_q;
    on_d    = on_q;
    if (cmd_pop_o) begin
      sweep_d = '0;
      on_d    = cmd_i.on;
    end else if ((state_q == ST_CLEAR) || (state_q == ST_FILL)) begin
      sweep_d = sweep_q + AddrW'(1);
    end
  end

  // Reset starts a pass that writes zeros through every byte of the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
      on_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      on_q    <= on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      px_q      <= cmd_i.x0;
      py_q      <= cmd_i.y0;
      qx_q      <= cmd_i.x1;
      qy_q      <= cmd_i.y1;
      dx_q      <= cmd_i.dx;
      dym_q     <= cmd_i.dy_mag;
      sxn_q     <= cmd_i.step_x_neg;
      syn_q     <= cmd_i.step_y_neg;
      err_q     <= signed'(ERR_W'(cmd_i.dx)) - signed'(ERR_W'(cmd_i.dy_mag));
      is_read_q <= (cmd_i.op == OP_READ);
    end else if ((state_q == ST_LINE_WR) && !line_done) begin
      err_q <= err_next;
      if (step_x) px_q <= sxn_q ? px_q - COORD_W'(1) : px_q + COORD_W'(1);
      if (step_y) py_q <= syn_q ? py_q - COORD_W'(1) : py_q + COORD_W'(1);
    end
    if (rd_en) begin
      addr_q <= raddr;
      vis_q  <= visible;
      bit_q  <= py_q[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfld_resq.sv
// Two-entry result queue between the back end and the result port.
// Depends on nothing outside this file.
`default_nettype none

module mfld_resq (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic value_i,
  output logic      full_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output logic      value_o
);

  logic [1:0] data_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign value_o = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + 2'(do_push) - 2'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mono_framebuffer_line_drawer.sv
// Sequence per command: a line reads and then writes each pixel it walks (LINE_RD, then
// LINE_WR); a pixel read passes through PIX_RD; a fill writes every byte of the store; each
// command then offers its result from the RESULT state.
// Throughput: one command at a time in the back end, set by the read-modify-write of each
// pixel through the single frame memory port; up to two commands queue ahead of it.
// Reset: asynchronous, active low; afterwards a pass over every byte zeroes the store
// while full_o stays high. Configuration writes are always taken.
`default_nettype none

module mono_framebuffer_line_drawer
  import mfld_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [1:0]            command_i,
  input  wire logic [COORD_W-1:0]    start_x_i,
  input  wire logic [COORD_W-1:0]    start_y_i,
  input  wire logic [COORD_W-1:0]    end_x_i,
  input  wire logic [COORD_W-1:0]    end_y_i,
  input  wire logic                  pixel_on_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic                       pixel_value_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned StoreDepth =
      MAX_WIDTH * ((MAX_HEIGHT + ROWS_PER_BYTE - 1) / ROWS_PER_BYTE);
  localparam logic [GEOM_W-1:0] MaxW = GEOM_W'(MAX_WIDTH);
  localparam logic [GEOM_W-1:0] MaxH = GEOM_W'(MAX_HEIGHT);

  logic [7:0] width_q, width_d;
  logic [6:0] height_q, height_d;
  geom_t      geom;
  logic       cmd_valid, cmd_pop, clearing, res_full, res_push, res_value;
  cmd_t       cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_d = cfg_data_i;
        REG_SCREEN_HEIGHT: height_d = cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 7'd64;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Geometry larger than the store acts as the store size.
  always_comb begin
    geom.width  = (GEOM_W'(width_q) > MaxW) ? MaxW : GEOM_W'(width_q);
    geom.height = (GEOM_W'(height_q) > MaxH) ? MaxH : GEOM_W'(height_q);
  end

  mfld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .command_i   (command_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .pixel_on_i  (pixel_on_i),
    .hold_i      (clearing),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mfld_back #(
    .STORE_DEPTH (StoreDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_value_o (res_value),
    .clearing_o  (clearing)
  );

  mfld_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .value_i (res_value),
    .full_o  (res_full),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .value_o (pixel_value_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mfld_checker.sv
// Port-level checks for the line drawer, bound to the top level.
// Depends on mono_framebuffer_line_drawer.
`default_nettype none

module mfld_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic push_i,
  input wire logic full_o,
  input wire logic empty_o,
  input wire logic pop_i,
  input wire logic pixel_value_o
);

  // Two queued commands, one in execution and two finished results.
  localparam logic [3:0] MaxOutstanding = 4'd5;

  logic [3:0] outstanding_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = push_i && !full_o;
  assign out_xfer = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= 4'd0;
    end else begin
      outstanding_q <= outstanding_q + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (outstanding_q != 4'd0))
    else $error("result shown with no command outstanding");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= MaxOutstanding)
    else $error("more commands taken than the block can hold");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> full_o)
    else $error("command port open before the store has been cleared");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(pixel_value_o)))
    else $error("waiting result changed or vanished without a transfer");

endmodule

bind mono_framebuffer_line_drawer mfld_checker u_mfld_checker (.*);

`default_nettype wire

FILE: verif/tb_mono_framebuffer_line_drawer.sv
// Self-checking testbench for the monochrome frame buffer line drawer.
// Predicts every command against its own copy of the frame store and geometry registers.
// Depends on mfld_pkg and mono_framebuffer_line_drawer from the rtl folder.
module tb_mono_framebuffer_line_drawer;
  timeunit 1ns;
  timeprecision 1ps;

  import mfld_pkg::*;

  localparam int MAX_W        = 128;
  localparam int MAX_H        = 64;
  localparam int STORE_DEPTH  = MAX_W * ((MAX_H + ROWS_PER_BYTE - 1) / ROWS_PER_BYTE);
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int LONG_HOLD    = 3000;
  localparam int SETTLE       = 12;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               on;
  } gfx_cmd_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  push_i        = 1'b0;
  logic                  full_o;
  logic [1:0]            command_i     = '0;
  logic [COORD_W-1:0]    start_x_i     = '0;
  logic [COORD_W-1:0]    start_y_i     = '0;
  logic [COORD_W-1:0]    end_x_i       = '0;
  logic [COORD_W-1:0]    end_y_i       = '0;
  logic                  pixel_on_i    = 1'b0;
  logic                  empty_o;
  logic                  pop_i         = 1'b0;
  logic                  pixel_value_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  mono_framebuffer_line_drawer #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .command_i     (command_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_on_i    (pixel_on_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .pixel_value_o (pixel_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted frame store and geometry registers.
  logic [7:0] frame_img [STORE_DEPTH];
  logic [7:0] model_width;
  logic [6:0] model_height;

  gfx_cmd_t pending_cmds [$];
  bit       expected_pixels [$];
  int       recent_x [$];
  int       recent_y [$];

  int queued_count = 0;
  int sent_count   = 0;
  int checked      = 0;
  int fail_count   = 0;
  int n_lines      = 0;
  int n_reads      = 0;
  int n_fills      = 0;
  int n_unused     = 0;
  int n_cfg        = 0;
  int full_stalls  = 0;
  int cycle_count  = 0;

  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int n_holds   = 0;

  function automatic bit locate(int x, int y, output int a);
    int w, h;
    w = (model_width > MAX_W) ? MAX_W : int'(model_width);
    h = (model_height > MAX_H) ? MAX_H : int'(model_height);
    a = 0;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    a = x + w * (y / ROWS_PER_BYTE);
    return a < STORE_DEPTH;
  endfunction

  function automatic void plot(int x, int y, bit on);
    int a;
    logic [7:0] mask;
    if (!locate(x, y, a)) return;
    mask = 8'(1 << (y % ROWS_PER_BYTE));
    frame_img[a] = on ? (frame_img[a] | mask) : (frame_img[a] & ~mask);
  endfunction

  function automatic bit read_pixel(int x, int y);
    int a;
    if (!locate(x, y, a)) return 1'b0;
    return frame_img[a][y % ROWS_PER_BYTE];
  endfunction

  // Integer error walk from (px, py) to (qx, qy), both ends included.
  function automatic void trace_line(int px, int py, int qx, int qy, bit on);
    int dx, dy, sx, sy, err, e2;
    dx  = (qx > px) ? qx - px : px - qx;
    dy  = (qy > py) ? py - qy : qy - py;
    sx  = (px < qx) ? 1 : -1;
    sy  = (py < qy) ? 1 : -1;
    err = dx + dy;
    for (int n = 0; n < 1024; n++) begin
      plot(px, py, on);
      if (px == qx && py == qy) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        px  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        py  += sy;
      end
    end
  endfunction

  function automatic bit apply_command(gfx_cmd_t c);
    bit val;
    val = 1'b0;
    case (c.cmd)
      CMD_LINE: begin
        trace_line(c.x0, c.y0, c.x1, c.y1, c.on);
        n_lines++;
      end
      CMD_READ: begin
        val = read_pixel(c.x0, c.y0);
        n_reads++;
      end
      CMD_FILL: begin
        foreach (frame_img[i]) frame_img[i] = {8{c.on}};
        n_fills++;
      end
      default: n_unused++;
    endcase
    return val;
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, int x0, int y0, int x1, int y1, bit on);
    gfx_cmd_t c;
    c.cmd = cmd;
    c.x0  = 8'(x0);
    c.y0  = 8'(y0);
    c.x1  = 8'(x1);
    c.y1  = 8'(y1);
    c.on  = on;
    pending_cmds.push_back(c);
    queued_count++;
    if (cmd == CMD_LINE) begin
      recent_x.push_back(x0);
      recent_y.push_back(y0);
      recent_x.push_back(x1);
      recent_y.push_back(y1);
      while (recent_x.size() > 16) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end
  endfunction

  // Mostly near the active area, sometimes anywhere in the coordinate range.
  function automatic int pick_coord(int span);
    int hi;
    if ($urandom_range(3, 0) == 0) return $urandom_range(255, 0);
    hi = (span + 3 > 255) ? 255 : span + 3;
    return $urandom_range(hi, 0);
  endfunction

  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(24, 0)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic void gen_random(int count, int read_pct);
    int w, h, r, k, idx, x0, y0, x1, y1;
    w = (model_width > MAX_W) ? MAX_W : int'(model_width);
    h = (model_height > MAX_H) ? MAX_H : int'(model_height);
    repeat (count) begin
      r = $urandom_range(99, 0);
      if (r < 2) begin
        queue_cmd(CMD_FILL, $urandom_range(255, 0), $urandom_range(255, 0),
                  $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(1, 0));
      end else if (r < 4) begin
        queue_cmd(CMD_UNUSED, $urandom_range(255, 0), $urandom_range(255, 0),
                  $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(1, 0));
      end else if (r < 4 + read_pct) begin
        k = $urandom_range(99, 0);
        if (k < 45 && recent_x.size() != 0) begin
          idx = $urandom_range(recent_x.size() - 1, 0);
          x0  = recent_x[idx];
          y0  = recent_y[idx];
        end else if (k < 90) begin
          x0 = pick_coord(w);
          y0 = pick_coord(h);
        end else begin
          x0 = $urandom_range(255, 0);
          y0 = $urandom_range(255, 0);
        end
        queue_cmd(CMD_READ, x0, y0, $urandom_range(255, 0), $urandom_range(255, 0),
                  $urandom_range(1, 0));
      end else begin
        x0 = pick_coord(w);
        y0 = pick_coord(h);
        if ($urandom_range(9, 0) < 7) begin
          x1 = near(x0);
          y1 = near(y0);
        end else begin
          x1 = pick_coord(w);
          y1 = pick_coord(h);
        end
        queue_cmd(CMD_LINE, x0, y0, x1, y1, $urandom_range(9, 0) < 7);
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  model_width  = data;
      REG_SCREEN_HEIGHT: model_height = data[6:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic wait_drained();
    while (!(sent_count == queued_count && expected_pixels.size() == 0)) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  gfx_cmd_t offered;
  bit       send_now;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk_i) begin
    send_now = push_i;
    if (push_i && full_o) full_stalls++;
    if (push_i && !full_o) begin
      expected_pixels.push_back(apply_command(offered));
      sent_count++;
      send_now = 1'b0;
    end
    if (!send_now && rst_ni) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        offered    = pending_cmds.pop_front();
        command_i  <= offered.cmd;
        start_x_i  <= offered.x0;
        start_y_i  <= offered.y0;
        end_x_i    <= offered.x1;
        end_y_i    <= offered.y1;
        pixel_on_i <= offered.on;
        send_now   = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
        end else begin
          burst_left--;
        end
      end
    end
    push_i <= send_now;
  end

  // Long receiver hold, started whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= LONG_HOLD;
      hold_ack  <= hold_req;
      n_holds++;
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  bit expected_bit;
  bit take;
  int stall_left = 0;
  int run_left   = 0;

  always @(posedge clk_i) begin
    if (pop_i && !empty_o) begin
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result transfer: pixel_value %0b", pixel_value_o);
      end else begin
        expected_bit = expected_pixels.pop_front();
        if (pixel_value_o !== expected_bit) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: pixel_value expected %0b, got %0b",
                     checked, expected_bit, pixel_value_o);
        end
        checked++;
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      take = 1'b0;
    end else if (run_left != 0) begin
      run_left--;
      take = 1'b1;
    end else begin
      run_left   = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 50) : $urandom_range(30, 0);
      stall_left = $urandom_range(12, 0);
      take       = (stall_left == 0);
    end
    if (hold_left != 0) take = 1'b0;
    pop_i <= take;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    foreach (frame_img[i]) frame_img[i] = 8'h00;
    model_width  = 8'd128;
    model_height = 7'd64;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The store is cleared after reset while full_o stays high.
    while (full_o !== 1'b0) @(posedge clk_i);

    // Directed commands on the reset geometry.
    queue_cmd(CMD_FILL,   0,   0,   0,   0, 1'b1);
    queue_cmd(CMD_READ,   0,   0,   0,   0, 1'b0);
    queue_cmd(CMD_READ, 127,  63, 255, 255, 1'b1);
    queue_cmd(CMD_READ, 128,   0,   0,   0, 1'b0);
    queue_cmd(CMD_FILL, 255, 255, 255, 255, 1'b0);
    queue_cmd(CMD_READ,   5,   5,   0,   0, 1'b0);
    queue_cmd(CMD_LINE,   0,   0, 127,  63, 1'b1);
    queue_cmd(CMD_READ,   0,   0,   0,   0, 1'b0);
    queue_cmd(CMD_READ, 127,  63,   0,   0, 1'b0);
    queue_cmd(CMD_READ,  64,  32,   0,   0, 1'b0);
    queue_cmd(CMD_LINE, 127,   0,   0,  63, 1'b1);
    queue_cmd(CMD_LINE,  10,  40,  10,   5, 1'b1);
    queue_cmd(CMD_LINE, 100,  20,   3,  20, 1'b1);
    queue_cmd(CMD_READ,  50,  20,   0,   0, 1'b0);
    queue_cmd(CMD_LINE,  30,  30,  30,  30, 1'b1);
    queue_cmd(CMD_READ,  30,  30,   0,   0, 1'b0);
    queue_cmd(CMD_LINE, 120,  60, 140,  70, 1'b1);
    queue_cmd(CMD_LINE, 200, 200, 255, 255, 1'b1);
    queue_cmd(CMD_READ, 255, 255, 255, 255, 1'b1);
    queue_cmd(CMD_LINE, 255,   0,   0, 255, 1'b1);
    queue_cmd(CMD_LINE,   0,   0, 127,  63, 1'b0);
    queue_cmd(CMD_READ,   0,   0,   0,   0, 1'b0);
    queue_cmd(CMD_UNUSED, 255, 255, 255, 255, 1'b1);
    queue_cmd(CMD_READ,  10,  20,   0,   0, 1'b0);
    queue_cmd(CMD_READ, 200,  10,   0,   0, 1'b0);
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, 8'd128);
    write_reg(REG_SCREEN_HEIGHT, 8'd64);
    gen_random(450, 40);
    wait_drained();

    // Zero width: nothing is on screen; height data with bit 7 set.
    write_reg(REG_SCREEN_WIDTH, 8'd0);
    write_reg(REG_SCREEN_HEIGHT, 8'hC8);
    gen_random(60, 40);
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, 8'd255);
    write_reg(REG_SCREEN_HEIGHT, 8'd8);
    gen_random(200, 40);
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, 8'd1);
    write_reg(REG_SCREEN_HEIGHT, 8'd127);
    write_reg(REG_SPARE_A, 8'(($urandom_range(255, 0))));
    write_reg(REG_SPARE_B, 8'(($urandom_range(255, 0))));
    gen_random(120, 40);
    wait_drained();

    // Mostly quick reads while the receiver holds off, so the block backs up.
    write_reg(REG_SCREEN_WIDTH, 8'd77);
    write_reg(REG_SCREEN_HEIGHT, 8'd40);
    hold_req++;
    gen_random(300, 75);
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, 8'($urandom_range(128, 1)));
    write_reg(REG_SCREEN_HEIGHT, 8'($urandom_range(64, 8)));
    gen_random(200, 40);
    wait_drained();

    write_reg(REG_SCREEN_WIDTH, 8'd128);
    write_reg(REG_SCREEN_HEIGHT, 8'd64);
    gen_random(350, 40);
    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d commands (%0d lines, %0d reads, %0d fills, %0d unused), %0d checked.",
             sent_count, n_lines, n_reads, n_fills, n_unused, checked);
    $display("%0d register writes, %0d cycles with input held off, %0d long receiver holds.",
             n_cfg, full_stalls, n_holds);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
